[rtl/ipv4_session_address_pool_assert.svh]
// Assertion macros for the IPv4 session address pool checker
`ifndef IPV4_SESSION_ADDRESS_POOL_ASSERT_SVH
`define IPV4_SESSION_ADDRESS_POOL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define IPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipa assertion failed");

// next-cycle implication
`define IPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipa assertion failed");

`endif

[rtl/ipa_pkg.sv]
// Package: constants, codes and port structs of the IPv4 session address pool
package ipa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int SID_W      = 64;
  localparam int ADDR_W     = 32;
  localparam int CNT_OUT_W  = 17;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_INIT    = 3'd4;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_EXISTING  = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_CFG   = 3'd4;

  localparam logic [1:0] CFG_BASE    = 2'd0;
  localparam logic [1:0] CFG_PREFIX  = 2'd1;
  localparam logic [1:0] CFG_GATEWAY = 2'd2;
  localparam logic [1:0] CFG_MAX     = 2'd3;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             valid;
    logic [SID_W-1:0] session;
  } slot_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } stk_wr_t;

endpackage

[rtl/ipa_slot_store.sv]
// Slot store: per-slot valid flag and bound session id, one write and one read port
module ipa_slot_store import ipa_pkg::*; (
  input  logic             clk,
  input  slot_wr_t         wr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_valid,
  output logic [SID_W-1:0] rd_session
);

  logic             valid_mem [POOL_DEPTH];
  logic [SID_W-1:0] sess_mem  [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      valid_mem[wr.addr] <= wr.valid;
      sess_mem[wr.addr]  <= wr.session;
    end
    if (rd_en) begin
      rd_valid   <= valid_mem[rd_addr];
      rd_session <= sess_mem[rd_addr];
    end
  end

endmodule

[rtl/ipa_free_stack.sv]
// Free stack memory: slot indices of unbound addresses
module ipa_free_stack import ipa_pkg::*; (
  input  logic             clk,
  input  stk_wr_t          wr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ipv4_session_address_pool.sv]
// Top level: sequencer of the IPv4 session address pool
// Allocate, release, lookup: one slot compared per cycle; a miss on allocate pops a free index.
// Query reads its slot via S_QRY, or goes to S_FIN outside the pool; unused opcodes go to S_FIN.
// One item in flight; a finished result waits in the output register while the next is taken.
// Reset (rst_n low, synchronous) clears counts and starts a clearing sweep of all POOL_DEPTH slots,
// as init does too; in_ready stays low until it ends. Config writes are taken at any time.
module ipv4_session_address_pool import ipa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_opcode,
  input  logic [SID_W-1:0]     in_session_id,
  input  logic [ADDR_W-1:0]    in_query_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [ADDR_W-1:0]    out_assigned_address,
  output logic                 out_address_in_use,
  output logic [CNT_OUT_W-1:0] out_free_count,
  output logic [CNT_OUT_W-1:0] out_bound_count,
  output logic [CNT_OUT_W-1:0] out_pool_total
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_POPWR  = 3'd4;
  localparam logic [2:0] S_QRY    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [31:0] base_r, base_nxt;
  logic [4:0]  prefix_r, prefix_nxt;
  logic        gw_r, gw_nxt;
  logic [15:0] max_r, max_nxt;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [SID_W-1:0]  sid_r, sid_nxt;
  logic [CNT_W-1:0]  scan_i_r, scan_i_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]  sweep_i_r, sweep_i_nxt;
  logic              init_pend_r, init_pend_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [CNT_W-1:0]  bound_r, bound_nxt;
  logic [CNT_W-1:0]  pool_r, pool_nxt;
  logic [ADDR_W-1:0] first_r, first_nxt;
  logic [2:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              res_inuse_r, res_inuse_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_inuse_r;
  logic [CNT_W-1:0]  out_free_r, out_bound_r, out_pool_r;
  logic              out_load;

  slot_wr_t          slot_wr;
  logic              slot_rd_en;
  logic [IDX_W-1:0]  slot_rd_addr;
  logic              slot_rd_valid;
  logic [SID_W-1:0]  slot_rd_session;
  stk_wr_t           stk_wr;
  logic              stk_rd_en;
  logic [IDX_W-1:0]  stk_rd_addr;
  logic [IDX_W-1:0]  stk_rd_data;

  // init, query and match arithmetic
  logic [31:0]       net_mask, net_addr;
  logic [5:0]        suffix_len;
  logic [32:0]       size_raw, size_cap1, size_cap2;
  logic [ADDR_W-1:0] q_off;
  logic [ADDR_W-1:0] hit_addr;
  logic              hit;

  ipa_slot_store u_slots (
    .clk        (clk),
    .wr         (slot_wr),
    .rd_en      (slot_rd_en),
    .rd_addr    (slot_rd_addr),
    .rd_valid   (slot_rd_valid),
    .rd_session (slot_rd_session)
  );

  ipa_free_stack u_stack (
    .clk     (clk),
    .wr      (stk_wr),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  always_comb begin
    base_nxt   = base_r;
    prefix_nxt = prefix_r;
    gw_nxt     = gw_r;
    max_nxt    = max_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE:    base_nxt   = cfg_wr_data;
        CFG_PREFIX:  prefix_nxt = cfg_wr_data[4:0];
        CFG_GATEWAY: gw_nxt     = cfg_wr_data[0];
        CFG_MAX:     max_nxt    = cfg_wr_data[15:0];
        default:     base_nxt   = base_r;
      endcase
    end
  end

  always_comb begin
    net_mask   = ~(32'hFFFF_FFFF >> prefix_r);
    net_addr   = base_r & net_mask;
    suffix_len = 6'd32 - {1'b0, prefix_r};
    size_raw   = (33'd1 << suffix_len) - 33'd2 - {32'd0, gw_r};
    size_cap1  = (max_r != 16'd0 && size_raw > {17'd0, max_r}) ? {17'd0, max_r} : size_raw;
    size_cap2  = (size_cap1 > 33'(POOL_DEPTH)) ? 33'(POOL_DEPTH) : size_cap1;
    q_off      = in_query_address - first_r;
    hit        = cmp_vld_r && slot_rd_valid && (slot_rd_session == sid_r);
    hit_addr   = first_r + {{(ADDR_W-IDX_W){1'b0}}, cmp_idx_r};
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    sid_nxt        = sid_r;
    scan_i_nxt     = scan_i_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    sweep_i_nxt    = sweep_i_r;
    init_pend_nxt  = init_pend_r;
    depth_nxt      = depth_r;
    bound_nxt      = bound_r;
    pool_nxt       = pool_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_inuse_nxt  = res_inuse_r;
    slot_wr        = '0;
    stk_wr         = '0;
    slot_rd_en     = 1'b0;
    slot_rd_addr   = scan_i_r[IDX_W-1:0];
    stk_rd_en      = 1'b0;
    stk_rd_addr    = sweep_i_r;
    in_ready       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        slot_wr.en   = 1'b1;
        slot_wr.addr = sweep_i_r;
        stk_wr.en    = 1'b1;
        stk_wr.addr  = sweep_i_r;
        stk_wr.data  = sweep_i_r;
        sweep_i_nxt  = sweep_i_r + 1'b1;
        if (sweep_i_r == IDX_W'(POOL_DEPTH - 1)) begin
          state_nxt     = init_pend_r ? S_FIN : S_IDLE;
          init_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt         = in_opcode;
          sid_nxt        = in_session_id;
          res_status_nxt = ST_DONE;
          res_addr_nxt   = '0;
          res_inuse_nxt  = 1'b0;
          scan_i_nxt     = '0;
          unique case (in_opcode)
            OP_ALLOC, OP_RELEASE, OP_LOOKUP: state_nxt = S_SCAN;
            OP_QUERY: begin
              slot_rd_en   = 1'b1;
              slot_rd_addr = q_off[IDX_W-1:0];
              state_nxt    = (q_off < {{(ADDR_W-CNT_W){1'b0}}, pool_r}) ? S_QRY : S_FIN;
            end
            OP_INIT: begin
              sweep_i_nxt   = '0;
              init_pend_nxt = 1'b1;
              state_nxt     = S_CLEAR;
              bound_nxt     = '0;
              if (prefix_r == 5'd31) begin
                res_status_nxt = ST_BAD_CFG;
                pool_nxt       = '0;
                depth_nxt      = '0;
                first_nxt      = '0;
              end else begin
                pool_nxt  = size_cap2[CNT_W-1:0];
                depth_nxt = size_cap2[CNT_W-1:0];
                first_nxt = net_addr + 32'd1 + {31'd0, gw_r};
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_addr_nxt = hit_addr;
          state_nxt    = S_FIN;
          if (op_r == OP_ALLOC) begin
            res_status_nxt = ST_EXISTING;
          end else if (op_r == OP_RELEASE) begin
            slot_wr.en      = 1'b1;
            slot_wr.addr    = cmp_idx_r;
            slot_wr.session = sid_r;
            if (bound_r != '0) begin
              bound_nxt = bound_r - 1'b1;
            end
            if (depth_r < CNT_W'(POOL_DEPTH)) begin
              stk_wr.en   = 1'b1;
              stk_wr.addr = depth_r[IDX_W-1:0];
              stk_wr.data = cmp_idx_r;
              depth_nxt   = depth_r + 1'b1;
            end
          end
        end else if (scan_i_r < pool_r) begin
          slot_rd_en  = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_i_r[IDX_W-1:0];
          scan_i_nxt  = scan_i_r + 1'b1;
        end else if (!cmp_vld_r) begin
          if (op_r == OP_ALLOC) begin
            if (depth_r == '0) begin
              res_status_nxt = ST_EXHAUSTED;
              state_nxt      = S_FIN;
            end else begin
              depth_nxt   = depth_r - 1'b1;
              stk_rd_en   = 1'b1;
              stk_rd_addr = depth_nxt[IDX_W-1:0];
              state_nxt   = S_POP;
            end
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_FIN;
          end
        end
      end
      S_POP: state_nxt = S_POPWR;
      S_POPWR: begin
        slot_wr.en      = 1'b1;
        slot_wr.addr    = stk_rd_data;
        slot_wr.valid   = 1'b1;
        slot_wr.session = sid_r;
        bound_nxt       = bound_r + 1'b1;
        res_addr_nxt    = first_r + {{(ADDR_W-IDX_W){1'b0}}, stk_rd_data};
        state_nxt       = S_FIN;
      end
      S_QRY: begin
        res_inuse_nxt = slot_rd_valid;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= 32'h0A08_0000;
      prefix_r    <= 5'd24;
      gw_r        <= 1'b1;
      max_r       <= 16'd0;
      state_r     <= S_CLEAR;
      sweep_i_r   <= '0;
      init_pend_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      depth_r     <= '0;
      bound_r     <= '0;
      pool_r      <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      prefix_r    <= prefix_nxt;
      gw_r        <= gw_nxt;
      max_r       <= max_nxt;
      state_r     <= state_nxt;
      sweep_i_r   <= sweep_i_nxt;
      init_pend_r <= init_pend_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      depth_r     <= depth_nxt;
      bound_r     <= bound_nxt;
      pool_r      <= pool_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sid_r        <= sid_nxt;
    scan_i_r     <= scan_i_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_inuse_r  <= res_inuse_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_inuse_r  <= res_inuse_r;
      out_free_r   <= depth_r;
      out_bound_r  <= bound_r;
      out_pool_r   <= pool_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_assigned_address = out_addr_r;
  assign out_address_in_use   = out_inuse_r;
  assign out_free_count       = {{(CNT_OUT_W-CNT_W){1'b0}}, out_free_r};
  assign out_bound_count      = {{(CNT_OUT_W-CNT_W){1'b0}}, out_bound_r};
  assign out_pool_total       = {{(CNT_OUT_W-CNT_W){1'b0}}, out_pool_r};

endmodule

[rtl/ipa_checker.sv]
// Port checker for the IPv4 session address pool, bound to the top level
`include "ipv4_session_address_pool_assert.svh"

module ipa_checker import ipa_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_wr_en,
  input logic [1:0]           cfg_index,
  input logic [31:0]          cfg_wr_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [2:0]           in_opcode,
  input logic [SID_W-1:0]     in_session_id,
  input logic [ADDR_W-1:0]    in_query_address,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [2:0]           out_status,
  input logic [ADDR_W-1:0]    out_assigned_address,
  input logic                 out_address_in_use,
  input logic [CNT_OUT_W-1:0] out_free_count,
  input logic [CNT_OUT_W-1:0] out_bound_count,
  input logic [CNT_OUT_W-1:0] out_pool_total
);

  // a stalled result holds
  `IPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_assigned_address))

  // free plus bound always accounts for the whole pool
  `IPA_ASSERT_IMP(a_count_sum, out_valid, ({1'b0, out_free_count} + {1'b0, out_bound_count}) == {1'b0, out_pool_total})

  // exhausted only with an empty stack and no address
  `IPA_ASSERT_IMP(a_exhausted, out_valid && out_status == ST_EXHAUSTED, out_free_count == '0 && out_assigned_address == '0)

  // in_ready is low again after every accepted request
  `IPA_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready)

endmodule

bind ipv4_session_address_pool ipa_checker u_ipa_checker (.*);

[tb/ipv4_session_address_pool_checker.sv]
// Checker for the IPv4 session address pool: predicts every reply and compares it
`timescale 1ns / 1ps
module ipv4_session_address_pool_checker import ipa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [2:0]           in_opcode,
  input  logic [SID_W-1:0]     in_session_id,
  input  logic [ADDR_W-1:0]    in_query_address,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           out_status,
  input  logic [ADDR_W-1:0]    out_assigned_address,
  input  logic                 out_address_in_use,
  input  logic [CNT_OUT_W-1:0] out_free_count,
  input  logic [CNT_OUT_W-1:0] out_bound_count,
  input  logic [CNT_OUT_W-1:0] out_pool_total,
  output int unsigned          accepted_count,
  output int unsigned          replies_pending,
  output int unsigned          fail_count
);

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_W-1:0]    addr;
    logic                 in_use;
    logic [CNT_OUT_W-1:0] free_cnt;
    logic [CNT_OUT_W-1:0] bound_cnt;
    logic [CNT_OUT_W-1:0] total;
  } pool_reply_t;

  pool_reply_t expected_replies[$];

  logic [31:0]      base_reg;
  logic [4:0]       prefix_reg;
  logic             gateway_reg;
  logic [15:0]      max_reg;

  logic [IDX_W-1:0] free_stk [POOL_DEPTH];
  bit               slot_busy [POOL_DEPTH];
  logic [SID_W-1:0] slot_sid [POOL_DEPTH];
  int unsigned      stk_depth;
  int unsigned      bound_now;
  int unsigned      pool_now;
  logic [31:0]      first_addr;

  function automatic int find_sid(logic [SID_W-1:0] sid);
    for (int i = 0; i < pool_now; i++)
      if (slot_busy[i] && slot_sid[i] == sid) return i;
    return -1;
  endfunction

  task automatic init_pool_model(output logic [2:0] st);
    logic [31:0] mask;
    logic [63:0] net, start, stop;
    foreach (slot_busy[i]) slot_busy[i] = 0;
    stk_depth  = 0;
    bound_now  = 0;
    pool_now   = 0;
    first_addr = '0;
    st = ST_DONE;
    if (prefix_reg >= 5'd31) begin
      st = ST_BAD_CFG;
      return;
    end
    mask  = (prefix_reg == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - prefix_reg));
    net   = {32'h0, base_reg & mask};
    start = net + 64'd1 + (gateway_reg ? 64'd1 : 64'd0);
    stop  = net + (64'd1 << (32 - prefix_reg)) - 64'd1;
    if (stop <= start) begin
      st = ST_BAD_CFG;
      return;
    end
    if (max_reg != 0 && stop - start > max_reg) stop = start + max_reg;
    if (stop - start > POOL_DEPTH) stop = start + POOL_DEPTH;
    first_addr = start[31:0];
    pool_now   = int'(stop - start);
    for (int i = 0; i < pool_now; i++) free_stk[i] = IDX_W'(i);
    stk_depth = pool_now;
  endtask

  task automatic predict_pool_reply(logic [2:0] op, logic [SID_W-1:0] sid,
                                    logic [ADDR_W-1:0] qa);
    pool_reply_t r;
    int s;
    int unsigned idx;
    logic [31:0] off;
    r = '0;
    case (op)
      OP_ALLOC: begin
        s = find_sid(sid);
        if (s >= 0) begin
          r.status = ST_EXISTING;
          r.addr   = first_addr + s;
        end else if (stk_depth == 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          stk_depth--;
          idx = free_stk[stk_depth];
          slot_busy[idx] = 1;
          slot_sid[idx]  = sid;
          bound_now++;
          r.addr = first_addr + idx;
        end
      end
      OP_RELEASE: begin
        s = find_sid(sid);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          slot_busy[s] = 0;
          if (bound_now > 0) bound_now--;
          if (stk_depth < POOL_DEPTH) begin
            free_stk[stk_depth] = IDX_W'(s);
            stk_depth++;
          end
          r.addr = first_addr + s;
        end
      end
      OP_LOOKUP: begin
        s = find_sid(sid);
        if (s < 0) r.status = ST_NOT_FOUND;
        else r.addr = first_addr + s;
      end
      OP_QUERY: begin
        off = qa - first_addr;
        if (off < pool_now && off < POOL_DEPTH && slot_busy[off]) r.in_use = 1;
      end
      OP_INIT: init_pool_model(r.status);
      default: ;
    endcase
    r.free_cnt  = CNT_OUT_W'(stk_depth);
    r.bound_cnt = CNT_OUT_W'(bound_now);
    r.total     = CNT_OUT_W'(pool_now);
    expected_replies.insert(expected_replies.size(), r);
  endtask

  function automatic int field_bad(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    accepted_count  = 0;
    replies_pending = 0;
    fail_count      = 0;
  end

  always @(posedge clk) begin
    pool_reply_t e;
    int bad;
    if (!rst_n) begin
      base_reg    = 32'h0A08_0000;
      prefix_reg  = 5'd24;
      gateway_reg = 1'b1;
      max_reg     = 16'd0;
      foreach (slot_busy[i]) slot_busy[i] = 0;
      stk_depth  = 0;
      bound_now  = 0;
      pool_now   = 0;
      first_addr = '0;
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply transfer with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_replies.pop_front();
          bad = field_bad("status", e.status, out_status)
              + field_bad("assigned_address", e.addr, out_assigned_address)
              + field_bad("address_in_use", e.in_use, out_address_in_use)
              + field_bad("free_count", e.free_cnt, out_free_count)
              + field_bad("bound_count", e.bound_cnt, out_bound_count)
              + field_bad("pool_total", e.total, out_pool_total);
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BASE:    base_reg    = cfg_wr_data;
          CFG_PREFIX:  prefix_reg  = cfg_wr_data[4:0];
          CFG_GATEWAY: gateway_reg = cfg_wr_data[0];
          CFG_MAX:     max_reg     = cfg_wr_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_pool_reply(in_opcode, in_session_id, in_query_address);
        accepted_count <= accepted_count + 1;
      end
    end
    replies_pending <= expected_replies.size();
  end

endmodule

[tb/ipv4_session_address_pool_test.sv]
// Testbench top for the IPv4 session address pool: stimulus, flow control and verdict
`timescale 1ns / 1ps
module ipv4_session_address_pool_test;
  import ipa_pkg::*;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 cfg_wr_en = 0;
  logic [1:0]           cfg_index = CFG_BASE;
  logic [31:0]          cfg_wr_data = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [2:0]           in_opcode = OP_QUERY;
  logic [SID_W-1:0]     in_session_id = '0;
  logic [ADDR_W-1:0]    in_query_address = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [2:0]           out_status;
  logic [ADDR_W-1:0]    out_assigned_address;
  logic                 out_address_in_use;
  logic [CNT_OUT_W-1:0] out_free_count;
  logic [CNT_OUT_W-1:0] out_bound_count;
  logic [CNT_OUT_W-1:0] out_pool_total;

  int unsigned accepted_count, replies_pending, fail_count;
  int unsigned send_gap_pct = 9;
  int unsigned recv_idle_pct = 73;
  int unsigned init_count = 0;
  int unsigned phase_count = 0;

  logic [31:0]      cur_base;
  logic [4:0]       cur_prefix;
  logic             cur_gw;
  logic [15:0]      cur_max;
  logic [SID_W-1:0] sid_set [16];

  always #5 clk = ~clk;

  ipv4_session_address_pool dut (.*);

  ipv4_session_address_pool_checker checker_i (.*);

  initial begin
    #100ms;
    $display("ipv4_session_address_pool_test failed");
    $finish;
  end

  // receiver: random idling, plus one long hold-off to back the block up
  initial begin
    bit held;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && accepted_count >= 40) begin
        held = 1;
        out_ready <= 0;
        repeat (400) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(logic [2:0] op, logic [SID_W-1:0] sid, logic [ADDR_W-1:0] qa);
    int unsigned n;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1;
    in_opcode        <= op;
    in_session_id    <= sid;
    in_query_address <= qa;
    if (op == OP_INIT) init_count++;
    n = accepted_count;
    do @(negedge clk); while (accepted_count == n);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(negedge clk);
    while (replies_pending != 0 || accepted_count == 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_pool(logic [31:0] b, logic [4:0] p, logic g, logic [15:0] m);
    logic [31:0] vals [4];
    vals = '{b, {27'h0, p}, {31'h0, g}, {16'h0, m}};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en   <= 1;
      cfg_index   <= 2'(i);
      cfg_wr_data <= vals[i];
      @(negedge clk);
    end
    cfg_wr_en <= 0;
    cur_base = b; cur_prefix = p; cur_gw = g; cur_max = m;
    phase_count++;
  endtask

  function automatic logic [31:0] near_pool_addr();
    logic [31:0] mask;
    mask = (cur_prefix == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - cur_prefix));
    return (cur_base & mask) + $urandom_range(0, 40);
  endfunction

  task automatic random_phase(int n);
    int unsigned r;
    logic [2:0] op;
    logic [SID_W-1:0] sid;
    logic [ADDR_W-1:0] qa;
    for (int i = 0; i < 16; i++) sid_set[i] = {$urandom, $urandom};
    sid_set[0] = '0;
    sid_set[1] = '1;
    send_item(OP_INIT, sid_set[2], near_pool_addr());
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 38) op = OP_ALLOC;
      else if (r < 62) op = OP_RELEASE;
      else if (r < 76) op = OP_LOOKUP;
      else if (r < 91) op = OP_QUERY;
      else if (r < 94) op = OP_INIT;
      else op = 3'($urandom_range(5, 7));
      sid = ($urandom_range(9) == 0) ? {$urandom, $urandom} : sid_set[$urandom_range(15)];
      qa  = ($urandom_range(4) == 0) ? $urandom : near_pool_addr();
      send_item(op, sid, qa);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;

    // before any init: empty pool, unused opcodes
    send_item(OP_ALLOC, 64'h1234, '0);
    send_item(OP_RELEASE, 64'h1234, '0);
    send_item(OP_LOOKUP, '1, '0);
    send_item(OP_QUERY, '0, '0);
    send_item(3'd5, '1, '1);
    send_item(3'd7, '0, '1);
    // reset settings give a 253-address pool
    send_item(OP_INIT, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, '1, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_LOOKUP, '1, '0);
    send_item(OP_QUERY, '0, 32'h0A08_00FE);
    send_item(OP_QUERY, '0, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_LOOKUP, '0, '0);
    drain();
    // no usable host, then two hosts and exhaustion
    set_pool(32'hC0A8_0101, 5'd31, 1'b1, 16'd0);
    send_item(OP_INIT, '0, '0);
    send_item(OP_ALLOC, 64'd7, '0);
    drain();
    set_pool(32'hC0A8_0107, 5'd30, 1'b0, 16'd0);
    send_item(OP_INIT, '0, '0);
    send_item(OP_ALLOC, 64'd1, '0);
    send_item(OP_ALLOC, 64'd2, '0);
    send_item(OP_ALLOC, 64'd3, '0);
    send_item(OP_QUERY, '0, 32'hC0A8_0105);
    drain();

    // random phases: idling modes rotate, pools kept small apart from one
    set_pool($urandom, 5'd28, 1'b1, 16'd0);          random_phase(70);
    set_pool($urandom, 5'd0, 1'b0, 16'd5);           random_phase(70);
    set_pool($urandom, 5'd20, 1'($urandom), 16'd7);  random_phase(70);
    send_gap_pct = 73; recv_idle_pct = 9;
    set_pool($urandom, 5'd16, 1'b0, 16'hFFFF);       random_phase(12);
    set_pool($urandom, 5'd30, 1'b1, 16'd0);          random_phase(50);
    set_pool($urandom, 5'd24, 1'b1, 16'd3);          random_phase(70);
    send_gap_pct = 0; recv_idle_pct = 0;
    set_pool($urandom, 5'd31, 1'b0, 16'd1);          random_phase(25);
    set_pool($urandom, 5'd29, 1'b0, 16'd0);          random_phase(70);
    set_pool($urandom, 5'd27, 1'($urandom), 16'd9);  random_phase(70);

    drain();
    repeat (1100) @(negedge clk);
    $display("Covered %0d requests over %0d pool settings with %0d inits,",
             accepted_count, phase_count, init_count);
    $display("including exhaustion, bad prefix, prefix zero and use before init.");
    if (fail_count == 0 && replies_pending == 0)
      $display("ipv4_session_address_pool_test passed");
    else
      $display("ipv4_session_address_pool_test failed");
    $finish;
  end

endmodule
